FILE: hdl/mia_pkg.sv
`default_nettype none
package mia_pkg;

  localparam int ElemW = 32;
  localparam int WideW = 192;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_COF_CLR,
    ST_COF_MUL,
    ST_COF_STEP,
    ST_COF_ACC,
    ST_DET_MUL,
    ST_DET_STEP,
    ST_DET_ACC,
    ST_OUT_SETUP,
    ST_DIV,
    ST_EMIT
  } mia_state_t;

  typedef struct packed {
    logic store_elem;
    logic cof_clear;
    logic cof_mul;
    logic cof_acc;
    logic det_clear;
    logic det_mul;
    logic det_acc;
    logic mul_step;
    logic div_setup;
    logic div_step;
    logic emit;
  } mia_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
  } mia_status_t;

  typedef logic signed [WideW-1:0] wide_t;

endpackage
`default_nettype wire

FILE: hdl/mia_datapath.sv
`default_nettype none
module mia_datapath
  import mia_pkg::*;
#(
  parameter int MAX_DIM = 4
) (
  input  wire logic                    clk,
  input  wire mia_cmd_t                cmd,
  input  wire logic [ElemW-1:0]        elem_in,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] elem_idx,
  input  wire logic [$clog2(MAX_DIM+1)-1:0] dim,
  input  wire logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] cof_idx,
  input  wire logic [4:0]              term_idx,
  output mia_status_t                  status,
  output logic signed [ElemW-1:0]      value,
  output logic                         singular,
  output logic                         clipped
);

  localparam int Cells = MAX_DIM * MAX_DIM;
  localparam int CW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int QW = 34;
  localparam int DVW = 2 * WideW;
  localparam int MW = 4 * ElemW;

  logic [ElemW-1:0] mat_r [Cells];
  wide_t adj_r [Cells];
  wide_t cof_acc_r, det_r, macc_r;
  logic [MW-1:0] ma_r;
  logic signed [ElemW-1:0] mb_r;
  logic [1:0] mcnt_r;
  logic [DVW-1:0] rem_r, den_r, num_r;
  logic [QW-1:0] q_r;
  logic [8:0] bit_r;
  logic neg_r, sing_r;

  // Cofactor of (ci,cj) in 0..3: term index walks permutations of the minor.
  logic [DW-1:0] ci, cj;
  logic [CW-1:0] ci_idx;
  assign ci_idx = CW'(cof_idx);
  always_comb begin
    int k;
    k = int'(cof_idx);
    ci = '0;
    cj = '0;
    case (int'(dim))
      2: begin
        ci = DW'(k >> 1);
        cj = DW'(k & 1);
      end
      3: begin
        if (k >= 6) begin
          ci = DW'(2);
          cj = DW'(k - 6);
        end else if (k >= 3) begin
          ci = DW'(1);
          cj = DW'(k - 3);
        end else begin
          cj = DW'(k);
        end
      end
      4: begin
        ci = DW'(k >> 2);
        cj = DW'(k & 3);
      end
      default: begin
        ci = '0;
        cj = '0;
      end
    endcase
  end

  // Enumerate minor permutations: rows/cols of the minor (size m = dim-1).
  logic [1:0] rows [3];
  logic [1:0] cols [3];
  logic [1:0] perm [3];
  logic       psign;
  logic       term_ok;
  always_comb begin
    int r, c, m;
    m = int'(dim) - 1;
    r = 0; c = 0;
    for (int a = 0; a < 3; a++) begin
      rows[a] = 2'd0; cols[a] = 2'd0;
    end
    for (int a = 0; a < 4; a++) begin
      if (a < int'(dim) && a != int'(ci)) begin
        if (r < 3) rows[r] = 2'(a);
        r = r + 1;
      end
      if (a < int'(dim) && a != int'(cj)) begin
        if (c < 3) cols[c] = 2'(a);
        c = c + 1;
      end
    end
    // Six permutations of three, with parity.
    case (term_idx[2:0])
      3'd0: begin perm[0] = 2'd0; perm[1] = 2'd1; perm[2] = 2'd2; psign = 1'b0; end
      3'd1: begin perm[0] = 2'd0; perm[1] = 2'd2; perm[2] = 2'd1; psign = 1'b1; end
      3'd2: begin perm[0] = 2'd1; perm[1] = 2'd0; perm[2] = 2'd2; psign = 1'b1; end
      3'd3: begin perm[0] = 2'd1; perm[1] = 2'd2; perm[2] = 2'd0; psign = 1'b0; end
      3'd4: begin perm[0] = 2'd2; perm[1] = 2'd0; perm[2] = 2'd1; psign = 1'b0; end
      default: begin perm[0] = 2'd2; perm[1] = 2'd1; perm[2] = 2'd0; psign = 1'b1; end
    endcase
    term_ok = 1'b1;
    for (int a = 0; a < 3; a++)
      if (a < m && int'(perm[a]) >= m) term_ok = 1'b0;
    if (m <= 1 && term_idx[2:0] != 3'd0) term_ok = 1'b0;
  end

  // Factors of the current term.
  logic signed [ElemW-1:0] fac [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (a < int'(dim) - 1)
        fac[a] = mat_r[CW'(int'(rows[a]) * int'(dim) + int'(cols[perm[a]]))];
      else
        fac[a] = ElemW'(1);
    end
  end

  // The wide operand is taken one 32-bit limb per step, most significant first.
  logic signed [ElemW:0] limb;
  logic signed [2*ElemW:0] pp;
  always_comb begin
    if (mcnt_r == 2'd0) limb = {ma_r[MW-1], ma_r[MW-1 -: ElemW]};
    else limb = {1'b0, ma_r[MW-1 -: ElemW]};
    pp = (2*ElemW+1)'(limb) * (2*ElemW+1)'(mb_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.store_elem) mat_r[CW'(elem_idx)] <= elem_in;
    if (cmd.cof_clear) cof_acc_r <= '0;
    if (cmd.cof_mul) begin
      ma_r <= MW'((2*ElemW)'(fac[0]) * (2*ElemW)'(fac[1]));
      mb_r <= fac[2];
      macc_r <= '0;
      mcnt_r <= '0;
    end
    if (cmd.det_mul) begin
      ma_r <= adj_r[CW'(term_idx)][MW-1:0];
      mb_r <= mat_r[CW'(term_idx)];
      macc_r <= '0;
      mcnt_r <= '0;
    end
    if (cmd.mul_step) begin
      macc_r <= {macc_r[WideW-ElemW-1:0], {ElemW{1'b0}}} + WideW'(pp);
      ma_r <= {ma_r[MW-ElemW-1:0], {ElemW{1'b0}}};
      mcnt_r <= mcnt_r + 2'd1;
    end
    if (cmd.cof_acc) begin
      wide_t cof_sum;
      cof_sum = cof_acc_r;
      if (term_ok) cof_sum = psign ? cof_acc_r - macc_r : cof_acc_r + macc_r;
      cof_acc_r <= cof_sum;
      if (term_idx[2:0] == 3'd5) begin
        adj_r[ci_idx] <= (ci[0] ^ cj[0]) ? -cof_sum : cof_sum;
      end
    end
    if (cmd.det_clear) det_r <= '0;
    if (cmd.det_acc) det_r <= det_r + macc_r;
    if (cmd.div_setup) begin
      wide_t cf, cm, dm;
      cf = adj_r[CW'(int'(cj) * int'(dim) + int'(ci))];
      cm = cf[WideW-1] ? -cf : cf;
      dm = det_r[WideW-1] ? -det_r : det_r;
      num_r <= DVW'({cm, 33'd0}) + DVW'(dm);
      den_r <= DVW'({dm, 1'b0});
      neg_r <= cf[WideW-1] ^ det_r[WideW-1];
      sing_r <= (det_r == '0);
      rem_r <= '0;
      q_r <= '0;
      bit_r <= 9'(DVW - 1);
    end
    if (cmd.div_step) begin
      logic [DVW-1:0] rs;
      rs = {rem_r[DVW-2:0], num_r[bit_r]};
      if (rs >= den_r) begin
        rem_r <= rs - den_r;
        q_r <= {q_r[QW-2:0], 1'b1} | (q_r[QW-1] ? {QW{1'b0}} | (QW'(1) << (QW-1)) : '0);
      end else begin
        rem_r <= rs;
        q_r <= {q_r[QW-2:0], 1'b0} | (q_r[QW-1] ? (QW'(1) << (QW-1)) : '0);
      end
      bit_r <= bit_r - 9'd1;
    end
  end

  always_comb begin
    status.div_done = (bit_r == 9'd0);
    status.mul_done = (mcnt_r == 2'd3);
  end

  always_comb begin
    logic [QW-1:0] lim;
    lim = neg_r ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
    singular = sing_r;
    clipped = 1'b0;
    value = '0;
    if (!sing_r) begin
      if (q_r > lim) begin
        clipped = 1'b1;
        value = neg_r ? 32'h80000000 : 32'h7FFFFFFF;
      end else begin
        value = neg_r ? -q_r[ElemW-1:0] : q_r[ElemW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mia_ctrl.sv
`default_nettype none
module mia_ctrl
  import mia_pkg::*;
#(
  parameter int MAX_DIM = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    cfg_we,
  input  wire logic [2:0]              cfg_data,
  input  wire mia_status_t             status,
  output logic                         busy,
  output mia_cmd_t                     cmd,
  output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] elem_idx,
  output logic [$clog2(MAX_DIM+1)-1:0] dim,
  output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] cof_idx,
  output logic [4:0]                   term_idx,
  output logic                         last
);

  localparam int IW = $clog2(MAX_DIM*MAX_DIM+1);
  localparam int NW = $clog2(MAX_DIM+1);

  mia_state_t state_r, state_nxt;
  logic [2:0] size_r;
  logic [IW-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [4:0] term_r, term_nxt;
  logic [IW-1:0] total;

  always_comb begin
    if (size_r == 3'd0) dim = NW'(1);
    else if (int'(size_r) > MAX_DIM) dim = NW'(MAX_DIM);
    else dim = NW'(size_r);
    total = IW'(int'(dim) * int'(dim));
  end

  assign elem_idx = cnt_r;
  assign cof_idx = idx_r;
  assign term_idx = term_r;
  assign last = (idx_r == total - IW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      size_r <= 3'd4;
      cnt_r <= '0;
      idx_r <= '0;
      term_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      term_r <= term_nxt;
      if (cfg_we) begin
        size_r <= cfg_data;
        cnt_r <= '0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    term_nxt = term_r;
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          if (cnt_r == total - IW'(1)) begin
            cnt_nxt = '0;
            idx_nxt = '0;
            state_nxt = ST_COF_CLR;
          end else begin
            cnt_nxt = cnt_r + IW'(1);
          end
        end
      end
      ST_COF_CLR: begin
        term_nxt = '0;
        state_nxt = ST_COF_MUL;
      end
      ST_COF_MUL: state_nxt = ST_COF_STEP;
      ST_COF_STEP: if (status.mul_done) state_nxt = ST_COF_ACC;
      ST_COF_ACC: begin
        if (term_r == 5'd5) begin
          if (idx_r == total - IW'(1)) begin
            idx_nxt = '0;
            term_nxt = '0;
            state_nxt = ST_DET_MUL;
          end else begin
            idx_nxt = idx_r + IW'(1);
            state_nxt = ST_COF_CLR;
          end
        end else begin
          term_nxt = term_r + 5'd1;
          state_nxt = ST_COF_MUL;
        end
      end
      ST_DET_MUL: state_nxt = ST_DET_STEP;
      ST_DET_STEP: if (status.mul_done) state_nxt = ST_DET_ACC;
      ST_DET_ACC: begin
        if (int'(term_r) == int'(dim) - 1) begin
          idx_nxt = '0;
          state_nxt = ST_OUT_SETUP;
        end else begin
          term_nxt = term_r + 5'd1;
          state_nxt = ST_DET_MUL;
        end
      end
      ST_OUT_SETUP: state_nxt = ST_DIV;
      ST_DIV: if (status.div_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (last) begin
          idx_nxt = '0;
          state_nxt = ST_LOAD;
        end else begin
          idx_nxt = idx_r + IW'(1);
          state_nxt = ST_OUT_SETUP;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_LOAD);
    case (state_r)
      ST_LOAD: cmd.store_elem = start;
      ST_COF_CLR: cmd.cof_clear = 1'b1;
      ST_COF_MUL: cmd.cof_mul = 1'b1;
      ST_COF_STEP: cmd.mul_step = 1'b1;
      ST_COF_ACC: begin
        cmd.cof_acc = 1'b1;
        cmd.det_clear = 1'b1;
      end
      ST_DET_MUL: cmd.det_mul = 1'b1;
      ST_DET_STEP: cmd.mul_step = 1'b1;
      ST_DET_ACC: cmd.det_acc = 1'b1;
      ST_OUT_SETUP: cmd.div_setup = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_EMIT: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/matrix_inverse_adjugate.sv
`default_nettype none
// Adjugate inverse of an N-by-N signed Q16.16 matrix, N from 1 to MAX_DIM.
// Input: raise start with in_element_value while busy is low; one word is
// taken per edge, row-major, N*N words per matrix, and the words of one
// matrix may follow back to back.
// Configuration: cfg_we with cfg_matrix_size sets N and drops a partial load.
// After the last word the block goes busy and takes no words until the last
// result is out. Each cofactor is a clear, then six three-factor terms, each
// one load, four 32-bit multiply steps and one accumulate. The determinant
// is then summed over the first-row terms in the same way. Each result then
// needs a setup, a 384-step restoring division and the cycle in which
// out_valid is high. The division dominates the busy time.
// out_last_element marks the final result. The receiver cannot stall; each
// result is valid on the output ports for one cycle only.
// Reset sets N to 4 and clears the load count.
module matrix_inverse_adjugate
  import mia_pkg::*;
#(
  parameter int MAX_DIM = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_matrix_size,
  output logic                    out_valid,
  output logic signed [31:0]      out_inverse_value,
  output logic                    out_singular,
  output logic                    out_clipped,
  output logic                    out_last_element
);

  localparam int IW = $clog2(MAX_DIM*MAX_DIM+1);
  localparam int NW = $clog2(MAX_DIM+1);

  mia_cmd_t cmd;
  mia_status_t status;
  logic [IW-1:0] elem_idx, cof_idx;
  logic [NW-1:0] dim;
  logic [4:0] term_idx;
  logic last;

  mia_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cfg_we(cfg_we),
    .cfg_data(cfg_matrix_size), .status(status), .busy(busy), .cmd(cmd),
    .elem_idx(elem_idx), .dim(dim), .cof_idx(cof_idx), .term_idx(term_idx),
    .last(last)
  );

  mia_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk(clk), .cmd(cmd), .elem_in(in_element_value),
    .elem_idx(elem_idx), .dim(dim), .cof_idx(cof_idx), .term_idx(term_idx),
    .status(status), .value(out_inverse_value), .singular(out_singular),
    .clipped(out_clipped)
  );

  assign out_valid = cmd.emit;
  assign out_last_element = last;

endmodule
`default_nettype wire

FILE: verif/mia_checker.sv
`timescale 1ns / 100ps
module mia_checker
  import mia_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_matrix_size,
  input  wire logic               out_valid,
  input  wire logic signed [31:0] out_inverse_value,
  input  wire logic               out_singular,
  input  wire logic               out_clipped,
  input  wire logic               out_last_element,
  output int                      fail_count,
  output int                      pending
);

  typedef struct {
    logic [31:0] value;
    logic        singular;
    logic        clipped;
    logic        last;
  } inv_word_t;

  inv_word_t   inverse_queue[$];
  logic [31:0] elems[16];
  logic [2:0]  size_reg;
  int          loaded;

  function automatic int dim_of(logic [2:0] s);
    if (s == 3'd0) return 1;
    if (s > 3'd4) return 4;
    return int'(s);
  endfunction

  function automatic wide_t el(int r, int c, int n);
    return wide_t'($signed(elems[r * n + c]));
  endfunction

  function automatic wide_t minor_det(int k, int rw[3], int cl[3], int n);
    wide_t d;
    d = '0;
    case (k)
      0: d = wide_t'(1);
      1: d = el(rw[0], cl[0], n);
      2: d = el(rw[0], cl[0], n) * el(rw[1], cl[1], n)
           - el(rw[0], cl[1], n) * el(rw[1], cl[0], n);
      default: begin
        d = el(rw[0], cl[0], n) * (el(rw[1], cl[1], n) * el(rw[2], cl[2], n)
                                 - el(rw[1], cl[2], n) * el(rw[2], cl[1], n))
          - el(rw[0], cl[1], n) * (el(rw[1], cl[0], n) * el(rw[2], cl[2], n)
                                 - el(rw[1], cl[2], n) * el(rw[2], cl[0], n))
          + el(rw[0], cl[2], n) * (el(rw[1], cl[0], n) * el(rw[2], cl[1], n)
                                 - el(rw[1], cl[1], n) * el(rw[2], cl[0], n));
      end
    endcase
    return d;
  endfunction

  function automatic wide_t cofactor_of(int i, int j, int n);
    int    rw[3];
    int    cl[3];
    int    mr;
    int    mc;
    wide_t d;
    mr = 0;
    mc = 0;
    rw = '{0, 0, 0};
    cl = '{0, 0, 0};
    for (int a = 0; a < n; a++) begin
      if (a != i) begin
        rw[mr] = a;
        mr++;
      end
      if (a != j) begin
        cl[mc] = a;
        mc++;
      end
    end
    d = minor_det(n - 1, rw, cl, n);
    return ((i + j) % 2 == 1) ? -d : d;
  endfunction

  task automatic predict_inverse(int n);
    wide_t          cof[16];
    wide_t          det;
    logic [255:0]   det_mag;
    logic [255:0]   mag;
    logic [255:0]   quot;
    logic [255:0]   lim;
    logic           neg;
    inv_word_t      w;
    det = '0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        cof[i * n + j] = cofactor_of(i, j, n);
    for (int j = 0; j < n; j++)
      det = det + el(0, j, n) * cof[j];
    det_mag = 256'(det < 0 ? -det : det);
    for (int k = 0; k < n * n; k++) begin
      w.value = '0;
      w.singular = (det == 0);
      w.clipped = 1'b0;
      w.last = (k == n * n - 1);
      if (det != 0) begin
        mag = 256'(cof[(k % n) * n + k / n] < 0 ? -cof[(k % n) * n + k / n]
                                                : cof[(k % n) * n + k / n]);
        neg = (cof[(k % n) * n + k / n] < 0) != (det < 0);
        quot = ((mag << 33) + det_mag) / (det_mag << 1);
        lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
        if (quot > lim) begin
          quot = lim;
          w.clipped = 1'b1;
        end
        w.value = neg ? 32'(0) - quot[31:0] : quot[31:0];
      end
      inverse_queue.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    inv_word_t exp_w;
    if (!rst_n) begin
      size_reg = 3'd4;
      loaded = 0;
      fail_count = 0;
      inverse_queue.delete();
    end else begin
      if (out_valid) begin
        if (inverse_queue.size() == 0) begin
          $error("unexpected inverse word %h", out_inverse_value);
          fail_count++;
        end else begin
          exp_w = inverse_queue.pop_front();
          if (out_inverse_value !== exp_w.value) begin
            $error("inverse_value expected %h actual %h", exp_w.value, out_inverse_value);
            fail_count++;
          end
          if (out_singular !== exp_w.singular) begin
            $error("singular expected %b actual %b", exp_w.singular, out_singular);
            fail_count++;
          end
          if (out_clipped !== exp_w.clipped) begin
            $error("clipped expected %b actual %b", exp_w.clipped, out_clipped);
            fail_count++;
          end
          if (out_last_element !== exp_w.last) begin
            $error("last_element expected %b actual %b", exp_w.last, out_last_element);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        size_reg = cfg_matrix_size;
        loaded = 0;
      end
      if (start && !busy) begin
        elems[loaded] = in_element_value;
        loaded++;
        if (loaded >= dim_of(size_reg) ** 2) begin
          loaded = 0;
          predict_inverse(dim_of(size_reg));
        end
      end
    end
    pending <= inverse_queue.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import mia_pkg::*;

  localparam int StallLimit = 40000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_element_value;
  logic               cfg_we;
  logic [2:0]         cfg_matrix_size;
  logic               out_valid;
  logic signed [31:0] out_inverse_value;
  logic               out_singular;
  logic               out_clipped;
  logic               out_last_element;
  int                 fail_count;
  int                 pending;
  int                 idle_pct;
  int                 words_sent;
  int                 quiet_cycles;
  logic [2:0]         cur_size;

  matrix_inverse_adjugate uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_element_value(in_element_value),
    .cfg_we(cfg_we), .cfg_matrix_size(cfg_matrix_size),
    .out_valid(out_valid), .out_inverse_value(out_inverse_value),
    .out_singular(out_singular), .out_clipped(out_clipped),
    .out_last_element(out_last_element)
  );

  mia_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_element_value(in_element_value),
    .cfg_we(cfg_we), .cfg_matrix_size(cfg_matrix_size),
    .out_valid(out_valid), .out_inverse_value(out_inverse_value),
    .out_singular(out_singular), .out_clipped(out_clipped),
    .out_last_element(out_last_element),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic [2:0] s);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_matrix_size <= s;
    cur_size = s;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int dim_now();
    if (cur_size == 3'd0) return 1;
    if (cur_size > 3'd4) return 4;
    return int'(cur_size);
  endfunction

  task automatic send_matrix(int kind);
    logic [31:0] m[16];
    int          n;
    n = dim_now();
    for (int k = 0; k < n * n; k++) begin
      case (kind)
        0, 1, 2, 3: m[k] = 32'($signed($urandom_range(32'h3FFFF)) - 32'sh20000);
        4, 5: m[k] = $urandom;
        6: m[k] = (k / n == n - 1 && n > 1) ? m[k - n] : $urandom;
        7: m[k] = ($urandom_range(3) == 0) ? $urandom : 32'd0;
        8: m[k] = 32'($signed($urandom_range(8)) - 4);
        default: m[k] = (k / n == k % n) ? 32'h0001_0000 : 32'd0;
      endcase
    end
    for (int k = 0; k < n * n; k++) send_word(m[k]);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_element_value = '0;
    cfg_we = 1'b0;
    cfg_matrix_size = 3'd4;
    cur_size = 3'd4;
    idle_pct = 0;
    words_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset size is four; the identity comes first.
    send_matrix(9);
    write_size(3'd1);
    send_word(32'd0);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'd1);
    send_word(32'hFFFF_FFFF);
    // A size write in the middle of a load drops the partial matrix.
    write_size(3'd2);
    send_word(32'h0002_0000);
    send_word(32'h0001_0000);
    write_size(3'd0);
    send_word(32'h0004_0000);
    write_size(3'd7);
    send_matrix(6);

    while (words_sent < 420) begin
      case ($urandom_range(3))
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 0;
        default: idle_pct = 37;
      endcase
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0: write_size(3'd0);
          1, 2, 3: write_size(3'd1);
          4, 5: write_size(3'd2);
          6, 7: write_size(3'd3);
          8: write_size(3'd4);
          default: write_size(3'($urandom_range(7, 5)));
        endcase
      end
      repeat ($urandom_range(3, 1)) send_matrix($urandom_range(9));
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
